FILE: src/sobel_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; every other file takes names from here by scope.
package sobel_pkg;

  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int GRAD_W     = 12;
  localparam int RAD_W      = 22;
  localparam int ROOT_W     = 11;
  localparam int REM_W      = 12;
  localparam int ROOT_STEPS = 11;
  localparam int STEP_W     = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int WREG_W     = 11;
  localparam int HREG_W     = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CH_W-1:0] EDGE_MAX = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic start;
    logic update;
    logic grad;
    logic square;
    logic root_step;
    logic load;
  } sobel_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic root_done;
    logic out_free;
  } sobel_status_t;

endpackage

FILE: src/sobel_in_if.sv
// Input pixel channel: valid/ready plus action and pixel payload.
// Depends on sobel_pkg for the pixel width.
interface sobel_in_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [sobel_pkg::PIX_W-1:0] pixel;

  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

FILE: src/sobel_out_if.sv
// Result channel: valid/ready plus blue, green and red edge magnitudes and frame_last.
// Depends on sobel_pkg for the channel width.
interface sobel_out_if;
  logic                        valid;
  logic                        ready;
  logic [sobel_pkg::CH_W-1:0]  edge_blue;
  logic [sobel_pkg::CH_W-1:0]  edge_green;
  logic [sobel_pkg::CH_W-1:0]  edge_red;
  logic                        frame_last;

  modport source (output valid, edge_blue, edge_green, edge_red, frame_last, input ready);
  modport sink   (input valid, edge_blue, edge_green, edge_red, frame_last, output ready);
endinterface

FILE: src/sobel_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on sobel_pkg for field widths.
interface sobel_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sobel_pkg::CFG_IDX_W-1:0]   index;
  logic [sobel_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/sobel_ctrl.sv
// Sequencing state machine: fetch, window update, gradient, square, root, emit.
// Depends on sobel_pkg for the command and status structs.
module sobel_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sobel_pkg::sobel_status_t status,
  output sobel_pkg::sobel_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FETCH  = 3'd1;
  localparam logic [2:0] ST_GRAD   = 3'd2;
  localparam logic [2:0] ST_SQUARE = 3'd3;
  localparam logic [2:0] ST_ROOT   = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.update = 1'b1;
        state_next = status.item_valid ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/sobel_datapath.sv
// Line memories, 3x3 window, position counters, gradient lanes, square root, output register.
// Depends on sobel_pkg; driven by sobel_ctrl through the command struct.
module sobel_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sobel_pkg::sobel_cmd_t             cmd,
  output sobel_pkg::sobel_status_t          status,
  input  logic                              in_action,
  input  sobel_pkg::pix_t                   in_pixel,
  input  logic                              cfg_we,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [sobel_pkg::CH_W-1:0]        out_blue,
  output logic [sobel_pkg::CH_W-1:0]        out_green,
  output logic [sobel_pkg::CH_W-1:0]        out_red,
  output logic                              out_last
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int GW = sobel_pkg::GRAD_W;

  // configuration
  logic [sobel_pkg::WREG_W-1:0] width_reg;
  logic [sobel_pkg::HREG_W-1:0] height_reg;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  // position and window
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_eff;
  sobel_pkg::pix_t px_q;
  sobel_pkg::pix_t top_q;
  sobel_pkg::pix_t mid_q;
  sobel_pkg::pix_t win [9];
  sobel_pkg::pix_t top_mem [MAX_WIDTH];
  sobel_pkg::pix_t mid_mem [MAX_WIDTH];
  logic [RW-1:0] orow;
  logic [CW-1:0] ocol;
  logic          last_q;

  // arithmetic
  logic signed [GW-1:0] gx [3];
  logic signed [GW-1:0] gy [3];
  logic signed [GW-1:0] gx_q [3];
  logic signed [GW-1:0] gy_q [3];
  logic [sobel_pkg::RAD_W-1:0]  rad  [3];
  logic [sobel_pkg::ROOT_W-1:0] root [3];
  logic [sobel_pkg::REM_W-1:0]  rem  [3];
  logic [sobel_pkg::CH_W-1:0]   mag  [3];
  logic [sobel_pkg::STEP_W-1:0] step_cnt;
  logic [8:0] ok;

  always_comb begin
    if (width_reg == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_reg);
    end
    if (height_reg == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_reg) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_reg);
    end
  end

  assign col_eff = (col >= w_eff) ? '0 : col;

  assign status.item_valid = (row >= RW'(2)) || (row == RW'(1) && col_eff != '0);
  assign status.root_done  = step_cnt == sobel_pkg::STEP_W'(sobel_pkg::ROOT_STEPS - 1);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= sobel_pkg::WIDTH_RESET;
      height_reg <= sobel_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sobel_pkg::REG_WIDTH:  width_reg  <= cfg_data[sobel_pkg::WREG_W-1:0];
        sobel_pkg::REG_HEIGHT: height_reg <= cfg_data[sobel_pkg::HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // line memories: read on accept, write back on update
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      top_q <= top_mem[col_eff[AW-1:0]];
      mid_q <= mid_mem[col_eff[AW-1:0]];
      px_q  <= in_action ? '0 : in_pixel;
    end
    if (cmd.update) begin
      top_mem[col_eff[AW-1:0]] <= mid_q;
      mid_mem[col_eff[AW-1:0]] <= px_q;
    end
  end

  // counters and window
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_index == sobel_pkg::REG_WIDTH ||
                           cfg_index == sobel_pkg::REG_HEIGHT)) ||
        (cmd.load && last_q)) begin
      col <= '0;
      row <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3+0] <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2] <= top_q;
      win[5] <= mid_q;
      win[8] <= px_q;
      if (32'(col_eff) + 32'd1 >= 32'(w_eff)) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col_eff + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (col_eff != '0) begin
        orow <= row - RW'(1);
        ocol <= col_eff - CW'(1);
      end else if (row >= RW'(2)) begin
        orow <= row - RW'(2);
        ocol <= w_eff - CW'(1);
      end else begin
        orow <= '0;
        ocol <= '0;
      end
    end
  end

  // border mask, row-major over the window
  always_comb begin
    logic top_ok, bot_ok, left_ok, right_ok;
    top_ok   = orow != '0;
    bot_ok   = (32'(orow) + 32'd1) < 32'(h_eff);
    left_ok  = ocol != '0;
    right_ok = (32'(ocol) + 32'd1) < 32'(w_eff);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ok[r*3+c] = !((r == 0 && !top_ok) || (r == 2 && !bot_ok) ||
                      (c == 0 && !left_ok) || (c == 2 && !right_ok));
      end
    end
  end

  always_comb begin
    logic signed [GW-1:0] v [9];
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        v[k] = ok[k] ? $signed({{(GW-sobel_pkg::CH_W){1'b0}}, win[k][ch*8 +: 8]}) : '0;
      end
      gx[ch] = v[2] - v[0] + ((v[5] - v[3]) <<< 1) + v[8] - v[6];
      gy[ch] = v[6] - v[0] + ((v[7] - v[1]) <<< 1) + v[8] - v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      for (int ch = 0; ch < 3; ch++) begin
        gx_q[ch] <= gx[ch];
        gy_q[ch] <= gy[ch];
      end
      last_q <= ((32'(orow) + 32'd1) >= 32'(h_eff)) &&
                ((32'(ocol) + 32'd1) == 32'(w_eff));
    end
  end

  // square then restoring square root, two radicand bits a step, one lane per channel
  always_ff @(posedge clk) begin
    logic signed [2*GW-1:0] sx, sy;
    logic [sobel_pkg::REM_W+1:0] rem_sh, trial;
    if (cmd.square) begin
      for (int ch = 0; ch < 3; ch++) begin
        sx = gx_q[ch] * gx_q[ch];
        sy = gy_q[ch] * gy_q[ch];
        rad[ch]  <= sx[sobel_pkg::RAD_W-1:0] + sy[sobel_pkg::RAD_W-1:0];
        root[ch] <= '0;
        rem[ch]  <= '0;
      end
      step_cnt <= '0;
    end else if (cmd.root_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_sh = {rem[ch], rad[ch][sobel_pkg::RAD_W-1 -: 2]};
        trial  = {1'b0, root[ch], 2'b01};
        rad[ch] <= rad[ch] << 2;
        if (rem_sh >= trial) begin
          rem[ch]  <= sobel_pkg::REM_W'(rem_sh - trial);
          root[ch] <= {root[ch][sobel_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem[ch]  <= sobel_pkg::REM_W'(rem_sh);
          root[ch] <= {root[ch][sobel_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      step_cnt <= step_cnt + sobel_pkg::STEP_W'(1);
    end
  end

  // round half up, clamp
  always_comb begin
    logic [sobel_pkg::ROOT_W:0] n;
    for (int ch = 0; ch < 3; ch++) begin
      n = {1'b0, root[ch]} +
          {{sobel_pkg::ROOT_W{1'b0}}, (rem[ch] > {1'b0, root[ch]})};
      mag[ch] = (n > 12'd255) ? sobel_pkg::EDGE_MAX : n[sobel_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_blue  <= mag[0];
      out_green <= mag[1];
      out_red   <= mag[2];
      out_last  <= last_q;
    end
  end

endmodule

FILE: src/sobel_edge_magnitude_rgb_top.sv
// Top level of the 3x3 Sobel edge magnitude block over RGB pixel streams.
// Depends on sobel_pkg, sobel_in_if, sobel_out_if, sobel_cfg_if, sobel_ctrl, sobel_datapath.
//
//  channel  | modport | payload                                     | role
//  ---------+---------+---------------------------------------------+---------------------
//  pix_in   | sink    | action, pixel[23:0]                         | pixel or flush tick
//  edge_out | source  | edge_blue, edge_green, edge_red, frame_last | at most one result per item
//  cfg      | sink    | index[1:0], data[12:0]                      | width / height write
//
// Steps: an item that yields no result passes accept and window update only.
// An item with a result then passes gradient, square, the 11-step square-root
// iteration and emit, which waits until the output register is free. Result
// registered, so the next item is accepted while it waits for edge_out.ready.
// Reset (rst, synchronous): width 640, height 480, counters and window zero.
// Line memories are not cleared; rows outside the image are masked.
// A write to the width or height register restarts the frame.
module sobel_edge_magnitude_rgb_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  sobel_in_if.sink    pix_in,
  sobel_out_if.source edge_out,
  sobel_cfg_if.sink   cfg
);

  sobel_pkg::sobel_cmd_t    cmd;
  sobel_pkg::sobel_status_t status;

  // writes must land only while idle, which the block itself does not enforce; always take them
  assign cfg.ready = 1'b1;

  sobel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_ready (pix_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sobel_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_action (pix_in.action),
    .in_pixel  (pix_in.pixel),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_ready (edge_out.ready),
    .out_valid (edge_out.valid),
    .out_blue  (edge_out.edge_blue),
    .out_green (edge_out.edge_green),
    .out_red   (edge_out.edge_red),
    .out_last  (edge_out.frame_last)
  );

`ifndef SYNTHESIS
  // never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> status.out_free) else $error("result overwritten");
  // every accepted transaction updates the window next cycle
  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> cmd.update) else $error("accept without update");
  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("overlapping commands");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the 3x3 Sobel edge magnitude block over RGB pixels.
// Depends on sobel_pkg, the three channel interfaces and sobel_edge_magnitude_rgb_top.
`timescale 1ns / 100ps

module testbench;

  localparam int MAXW = 1024;
  localparam int MAXH = 4096;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic        action;
    logic [23:0] pixel;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } edge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sobel_in_if  pix_in ();
  sobel_out_if edge_out ();
  sobel_cfg_if cfg ();

  sobel_edge_magnitude_rgb_top u_top (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_in),
    .edge_out (edge_out),
    .cfg      (cfg)
  );

  always #1 clk = ~clk;

  // Predictor state: register copies, line buffers, window and raster position.
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [23:0] line_top [MAXW];
  logic [23:0] line_mid [MAXW];
  logic [23:0] win [9];
  int unsigned col_pos, row_pos;

  pix_item_t    pending_items [$];
  edge_result_t expected_edges [$];

  int mismatches = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int items_sent = 0;
  bit stim_done = 0;
  int idle_cycles = 0;

  function automatic int unsigned eff_w();
    if (width_reg < 1) return 1;
    if (width_reg > MAXW) return MAXW;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg < 1) return 1;
    if (height_reg > MAXH) return MAXH;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < 9; i++) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Exact rounded square root, clamped to the channel maximum.
  function automatic logic [7:0] rounded_magnitude(int gx, int gy);
    int unsigned s, n;
    s = gx * gx + gy * gy;
    n = 0;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return (n > 255) ? sobel_pkg::EDGE_MAX : n[7:0];
  endfunction

  // Advance the predictor by one pixel transaction; queue a result if one is due.
  function automatic void predict_edges(pix_item_t it);
    int unsigned w, h, c, r, orow, ocol;
    logic [23:0] px, top, mid;
    bit has_result, ok;
    int v [9];
    int gx, gy;
    edge_result_t res;
    w = eff_w();
    h = eff_h();
    c = col_pos;
    r = row_pos;
    px = it.action ? 24'd0 : it.pixel;
    if (c >= w) c = 0;
    top = line_top[c];
    mid = line_mid[c];
    line_top[c] = mid;
    line_mid[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3] = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    has_result = (r >= 2) || (r == 1 && c >= 1);
    if (c >= 1) begin
      orow = r - 1;
      ocol = c - 1;
    end else if (r >= 2) begin
      orow = r - 2;
      ocol = w - 1;
    end else begin
      orow = 0;
      ocol = 0;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;
    if (!has_result) return;
    for (int ch = 0; ch < 3; ch++) begin
      for (int rr = 0; rr < 3; rr++)
        for (int cc = 0; cc < 3; cc++) begin
          ok = 1;
          if (rr == 0 && orow == 0) ok = 0;
          if (rr == 2 && orow + 1 >= h) ok = 0;
          if (cc == 0 && ocol == 0) ok = 0;
          if (cc == 2 && ocol + 1 >= w) ok = 0;
          v[rr*3+cc] = ok ? int'((win[rr*3+cc] >> (8*ch)) & 24'hFF) : 0;
        end
      gx = -v[0] + v[2] - 2*v[3] + 2*v[5] - v[6] + v[8];
      gy = -v[0] - 2*v[1] - v[2] + v[6] + 2*v[7] + v[8];
      case (ch)
        0: res.blue  = rounded_magnitude(gx, gy);
        1: res.green = rounded_magnitude(gx, gy);
        default: res.red = rounded_magnitude(gx, gy);
      endcase
    end
    res.last = (orow + 1 >= h) && (ocol + 1 == w);
    if (res.last) restart_frame();
    expected_edges.push_back(res);
  endfunction

  // Pixel driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      pix_in.valid  <= 1'b0;
      pix_in.action <= 1'b0;
      pix_in.pixel  <= '0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        predict_edges('{action: pix_in.action, pixel: pix_in.pixel});
        items_sent++;
      end
      // A transaction completes, or nothing is on the bus: pick what comes next.
      if (!pix_in.valid || pix_in.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_in.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          pix_item_t nx;
          nx = pending_items.pop_front();
          pix_in.valid  <= 1'b1;
          pix_in.action <= nx.action;
          pix_in.pixel  <= nx.pixel;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall on its own pattern, with stall-free stretches.
  int rx_phase = 0;
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rst) edge_out.ready <= 1'b0;
    else if ((rx_phase / 300) % 3 == 0) edge_out.ready <= 1'b1;
    else edge_out.ready <= ($urandom_range(0, 99) < 65);
  end

  // Monitor: compare each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && edge_out.valid && edge_out.ready) begin
      edge_result_t got, exp_r;
      got = '{blue: edge_out.edge_blue, green: edge_out.edge_green,
              red: edge_out.edge_red, last: edge_out.frame_last};
      results_seen++;
      if (got.last) frames_seen++;
      if (expected_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_edges.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp b=%0d g=%0d r=%0d l=%0b got b=%0d g=%0d r=%0d l=%0b",
                     results_seen, exp_r.blue, exp_r.green, exp_r.red, exp_r.last,
                     got.blue, got.green, got.red, got.last);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (edge_out.valid && edge_out.ready) ||
        (cfg.valid && cfg.ready) || (stim_done && expected_edges.size() == 0 &&
        pending_items.size() == 0))
      idle_cycles <= 0;
    else if (pending_items.size() > 0 || expected_edges.size() > 0 || pix_in.valid ||
             cfg.valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Register write: hold valid until the handshake, then update the predictor.
  task automatic write_reg(logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                           logic [sobel_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == sobel_pkg::REG_WIDTH) width_reg = val[10:0];
    else height_reg = val;
    restart_frame();
  endtask

  // Drop to idle: wait until everything queued has gone and all results arrived.
  task automatic wait_idle();
    while (pending_items.size() > 0 || pix_in.valid || expected_edges.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                 $urandom_range(0, 1) ? 8'hFF : 8'h00};
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // Queue one frame of w*h pixels plus w+1 flush ticks; sprinkle noise if asked.
  task automatic queue_frame(int w, int h, bit noisy);
    for (int i = 0; i < w * h; i++) begin
      pix_item_t it;
      it.action = noisy && ($urandom_range(0, 19) == 0);
      it.pixel = rand_pixel();
      pending_items.push_back(it);
    end
    for (int i = 0; i < w + 1; i++) begin
      pix_item_t it;
      it.action = !(noisy && ($urandom_range(0, 9) == 0));
      it.pixel = 24'($urandom_range(0, 24'hFFFFFF));
      pending_items.push_back(it);
    end
  endtask

  task automatic run_frame(int w, int h, bit noisy);
    write_reg(sobel_pkg::REG_WIDTH, sobel_pkg::CFG_DATA_W'(w));
    write_reg(sobel_pkg::REG_HEIGHT, sobel_pkg::CFG_DATA_W'(h));
    queue_frame(w < 1 ? 1 : (w > MAXW ? MAXW : w), h < 1 ? 1 : h, noisy);
    wait_idle();
  endtask

  initial begin
    int w, h, budget;
    width_reg = sobel_pkg::WIDTH_RESET;
    height_reg = sobel_pkg::HEIGHT_RESET;
    for (int i = 0; i < MAXW; i++) begin
      line_top[i] = '0;
      line_mid[i] = '0;
    end
    restart_frame();
    cfg.valid = 1'b0;
    cfg.index = sobel_pkg::REG_WIDTH;
    cfg.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: degenerate sizes, width and height zero clamp to one, all-ones/zeros pixels.
    write_reg(sobel_pkg::REG_WIDTH, sobel_pkg::CFG_DATA_W'(0));
    write_reg(sobel_pkg::REG_HEIGHT, sobel_pkg::CFG_DATA_W'(0));
    pending_items.push_back('{action: 1'b0, pixel: 24'hFFFFFF});
    pending_items.push_back('{action: 1'b1, pixel: 24'h000000});
    pending_items.push_back('{action: 1'b1, pixel: 24'hFFFFFF});
    wait_idle();
    run_frame(3, 3, 0);
    run_frame(1, 4, 0);
    run_frame(4, 1, 1);
    // Oversized width register clamps to the maximum; run just past the first row.
    write_reg(sobel_pkg::REG_WIDTH, sobel_pkg::CFG_DATA_W'(2047));
    write_reg(sobel_pkg::REG_HEIGHT, sobel_pkg::CFG_DATA_W'(2));
    for (int i = 0; i < MAXW + 6; i++)
      pending_items.push_back('{action: 1'b0, pixel: rand_pixel()});
    wait_idle();
    // Largest height register value clamps to the maximum height.
    write_reg(sobel_pkg::REG_HEIGHT, 13'h1FFF);
    write_reg(sobel_pkg::REG_WIDTH, sobel_pkg::CFG_DATA_W'(1));
    for (int i = 0; i < 20; i++)
      pending_items.push_back('{action: 1'b0, pixel: rand_pixel()});
    wait_idle();

    // Random frames: mostly well-formed small frames, some noisy.
    budget = 800;
    while (budget > 0) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      if ($urandom_range(0, 15) == 0) w = $urandom_range(1, 40);
      run_frame(w, h, $urandom_range(0, 4) == 0);
      budget -= w * h + w + 1;
    end
    stim_done = 1;
    wait_idle();

    $display("covered %0d pixel transactions, %0d results, %0d frames closed",
             items_sent, results_seen, frames_seen);
    if (mismatches == 0) $display("tb: success");
    else begin
      $display("%0d mismatches", mismatches);
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: sim.f
src/sobel_pkg.sv
src/sobel_in_if.sv
src/sobel_out_if.sv
src/sobel_cfg_if.sv
src/sobel_ctrl.sv
src/sobel_datapath.sv
src/sobel_edge_magnitude_rgb_top.sv
tb/testbench.sv
